@@ sv/hcm_pkg.sv @@
`default_nettype none
// hcm_pkg: types, constants and per-level functions of the hilbert curve map
// depends on nothing; used by the channel interfaces, the register file, the stages and the top level

package hcm_pkg;

  localparam int unsigned COORD_W          = 16;
  localparam int unsigned INDEX_W          = 2 * COORD_W;
  localparam int unsigned ORDER_W          = 5;
  localparam int unsigned MAX_ORDER        = 16;
  localparam int unsigned LEVELS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES       = COORD_W / LEVELS_PER_STAGE;
  localparam int unsigned PADDR_W          = 3;
  localparam int unsigned PDATA_W          = 32;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd13;

  typedef enum logic {
    CMD_IDX2XY = 1'b0,
    CMD_XY2IDX = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_CURVE_ORDER = 1'b0
  } reg_idx_e;

  // one word in flight; x/y and d are both the source and the result,
  // depending on direction
  typedef struct packed {
    cmd_e               cmd;
    logic               odd;   // effective order is odd: one net swap pending
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] d;
  } hcm_item_t;

  // saturate the order, drop unused bits, pre-swap for xy to index
  function automatic hcm_item_t hcm_prep(cmd_e cmd, logic [INDEX_W-1:0] idx,
                                         logic [COORD_W-1:0] xi, logic [COORD_W-1:0] yi,
                                         logic [ORDER_W-1:0] order);
    logic [ORDER_W-1:0] eff;
    logic [ORDER_W:0]   two_eff;
    logic [COORD_W-1:0] xm;
    logic [COORD_W-1:0] ym;
    hcm_item_t          it;
    eff     = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
    two_eff = {eff, 1'b0};
    it.cmd  = cmd;
    it.odd  = eff[0];
    it.x    = '0;
    it.y    = '0;
    it.d    = '0;
    for (int i = 0; i < COORD_W; i++) begin
      xm[i] = xi[i] & (ORDER_W'(i) < eff);
      ym[i] = yi[i] & (ORDER_W'(i) < eff);
    end
    if (cmd == CMD_IDX2XY) begin
      for (int i = 0; i < INDEX_W; i++) begin
        it.d[i] = idx[i] & ((ORDER_W + 1)'(i) < two_eff);
      end
    end else if (eff[0]) begin
      it.x = ym;
      it.y = xm;
    end else begin
      it.x = xm;
      it.y = ym;
    end
    return it;
  endfunction

  // index to xy, one level, smallest quadrant upward
  function automatic hcm_item_t hcm_i2xy_level(hcm_item_t it, int lvl);
    logic               rx;
    logic               ry;
    logic [COORD_W-1:0] m;
    logic [COORD_W-1:0] t;
    hcm_item_t          o;
    o  = it;
    m  = (COORD_W'(1) << lvl) - COORD_W'(1);
    rx = it.d[2*lvl+1];
    ry = it.d[2*lvl] ^ rx;
    if (!ry) begin
      if (rx) begin
        o.x = o.x ^ m;
        o.y = o.y ^ m;
      end
      t   = o.x;
      o.x = o.y;
      o.y = t;
    end
    o.x[lvl] = rx;
    o.y[lvl] = ry;
    return o;
  endfunction

  // xy to index, one level, largest quadrant downward
  function automatic hcm_item_t hcm_xy2i_level(hcm_item_t it, int lvl);
    logic               rx;
    logic               ry;
    logic [COORD_W-1:0] m;
    logic [COORD_W-1:0] t;
    hcm_item_t          o;
    o  = it;
    m  = (COORD_W'(1) << lvl) - COORD_W'(1);
    rx = it.x[lvl];
    ry = it.y[lvl];
    o.d[2*lvl+1] = rx;
    o.d[2*lvl]   = rx ^ ry;
    o.x[lvl]     = 1'b0;
    o.y[lvl]     = 1'b0;
    if (!ry) begin
      if (rx) begin
        o.x = o.x ^ m;
        o.y = o.y ^ m;
      end
      t   = o.x;
      o.x = o.y;
      o.y = t;
    end
    return o;
  endfunction

  // one stage worth of levels; the last stage also settles the result
  function automatic hcm_item_t hcm_group(hcm_item_t it, int grp);
    hcm_item_t          o;
    logic [COORD_W-1:0] t;
    o = it;
    for (int j = 0; j < LEVELS_PER_STAGE; j++) begin
      if (o.cmd == CMD_IDX2XY) begin
        o = hcm_i2xy_level(o, grp * LEVELS_PER_STAGE + j);
      end else begin
        o = hcm_xy2i_level(o, COORD_W - 1 - grp * LEVELS_PER_STAGE - j);
      end
    end
    if (grp == NUM_STAGES - 1) begin
      if (o.cmd == CMD_IDX2XY) begin
        // undo the swaps of the unused top levels
        if (o.odd) begin
          t   = o.x;
          o.x = o.y;
          o.y = t;
        end
        o.d = '0;
      end else begin
        o.x = '0;
        o.y = '0;
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ sv/hcm_in_if.sv @@
`default_nettype none
// hcm_in_if: request channel of the hilbert curve map
// depends on hcm_pkg for field widths

interface hcm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [hcm_pkg::INDEX_W-1:0]    index_in;
  logic [hcm_pkg::COORD_W-1:0]    x_in;
  logic [hcm_pkg::COORD_W-1:0]    y_in;

  modport source (output valid, command, index_in, x_in, y_in, input ready);
  modport sink   (input valid, command, index_in, x_in, y_in, output ready);
endinterface

`default_nettype wire

@@ sv/hcm_out_if.sv @@
`default_nettype none
// hcm_out_if: result channel of the hilbert curve map
// depends on hcm_pkg for field widths

interface hcm_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcm_pkg::COORD_W-1:0]    x_out;
  logic [hcm_pkg::COORD_W-1:0]    y_out;
  logic [hcm_pkg::INDEX_W-1:0]    index_out;

  modport source (output valid, x_out, y_out, index_out, input ready);
  modport sink   (input valid, x_out, y_out, index_out, output ready);
endinterface

`default_nettype wire

@@ sv/hcm_cfg.sv @@
`default_nettype none
// hcm_cfg: apb register file holding the curve order
// depends on hcm_pkg

module hcm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hcm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hcm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [hcm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [hcm_pkg::ORDER_W-1:0]   order_o
);
  import hcm_pkg::*;

  logic [ORDER_W-1:0] order_q;
  logic [ORDER_W-1:0] order_d;
  reg_idx_e           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    order_d = order_q;
    prdata  = '0;
    unique case (reg_idx)
      REG_CURVE_ORDER: begin
        prdata = PDATA_W'(order_q);
        if (wr_en) order_d = pwdata[ORDER_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else begin
      order_q <= order_d;
    end
  end

  assign order_o = order_q;

endmodule

`default_nettype wire

@@ sv/hcm_stage.sv @@
`default_nettype none
// hcm_stage: one pipeline stage, four curve levels of either direction
// depends on hcm_pkg

module hcm_stage #(
  parameter int unsigned GROUP = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hcm_pkg::hcm_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hcm_pkg::hcm_item_t      out_item_o
);
  import hcm_pkg::*;

  logic      valid_q;
  hcm_item_t item_q;
  hcm_item_t item_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign item_d     = hcm_group(in_item_i, int'(GROUP));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

@@ sv/hilbert_curve_map.sv @@
`default_nettype none
// hilbert_curve_map: top level, apb register plus four-stage conversion pipeline
// depends on hcm_pkg, hcm_in_if, hcm_out_if, hcm_cfg and hcm_stage

// Converts between a distance along a Hilbert curve and (x, y) on a grid of
// side 2^curve_order. A request word with command 0 maps index_in to x_out and
// y_out (index_out is zero); command 1 maps x_in, y_in to index_out (x_out and
// y_out are zero). Orders above 16 act as 16, index bits at or above twice the
// order and coordinate bits at or above the order are ignored. The block takes
// one word per clock while the result side does not stall; the pipeline is four
// register stages of four curve levels each, and a stall on the result side
// backs up stage by stage without dropping a word.
// curve_order sits at apb byte address 0 (reset value 13); change it only while
// no word is in flight.

module hilbert_curve_map (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hcm_in_if.sink                             in_i,
  hcm_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hcm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hcm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [hcm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import hcm_pkg::*;

  // configured order; the user keeps it stable while words are in flight, the block does not enforce it
  logic [ORDER_W-1:0] order;

  // stage chain: index k is the input side of stage k, NUM_STAGES is the output
  logic      valid [NUM_STAGES+1];
  logic      ready [NUM_STAGES+1];
  hcm_item_t item  [NUM_STAGES+1];

  hcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .order_o (order)
  );

  // masking and the pre-swap go in front of the first stage
  assign valid[0] = in_i.valid;
  assign in_i.ready = ready[0];
  assign item[0] = hcm_prep(cmd_e'(in_i.command), in_i.index_in, in_i.x_in, in_i.y_in,
                            order);

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    hcm_stage #(
      .GROUP (k)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_item_i   (item[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_item_o  (item[k+1])
    );
  end

  // last stage register is the result register; unused fields are already zero
  assign ready[NUM_STAGES] = out_o.ready;
  assign out_o.valid       = valid[NUM_STAGES];
  assign out_o.x_out       = item[NUM_STAGES].x;
  assign out_o.y_out       = item[NUM_STAGES].y;
  assign out_o.index_out   = item[NUM_STAGES].d;

endmodule

`default_nettype wire

@@ bench/hcm_checker.sv @@
`timescale 1ns / 1ps
// hcm_checker: watches the request, result and register ports of the hilbert curve map,
// predicts each result word from the accepted request words and compares it field by field
// depends on hcm_pkg and the hcm_in_if / hcm_out_if channel interfaces

module hcm_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hcm_in_if                                  req_i,
  hcm_out_if                                 rsp_i,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hcm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hcm_pkg::PDATA_W-1:0]   pwdata,
  input  wire logic [hcm_pkg::PDATA_W-1:0]   prdata,
  input  wire logic                          pready,
  output int unsigned                        mismatch_cnt_o,
  output int unsigned                        pending_cnt_o,
  output int unsigned                        coord_cnt_o,
  output int unsigned                        index_cnt_o
);
  import hcm_pkg::*;

  localparam logic [PADDR_W-1:0] ORDER_ADDR = PADDR_W'(4 * REG_CURVE_ORDER);

  typedef struct packed {
    cmd_e               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] idx;
  } curve_result_t;

  curve_result_t      expected_q [$];
  logic [ORDER_W-1:0] order_q;
  int unsigned        fail_total  = 0;
  int unsigned        in_flight   = 0;
  int unsigned        coord_total = 0;
  int unsigned        index_total = 0;

  assign mismatch_cnt_o = fail_total;
  assign pending_cnt_o  = in_flight;
  assign coord_cnt_o    = coord_total;
  assign index_cnt_o    = index_total;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    fail_total++;
  endtask

  // reflect within the quadrant when needed, then swap; returns {x, y}
  function automatic logic [63:0] fold_quadrant(logic [31:0] s, logic [31:0] rx,
                                                logic [31:0] ry, logic [31:0] x,
                                                logic [31:0] y);
    if (ry == 0) begin
      if (rx == 1) begin
        x = (s - 1 - x) & (s - 1);
        y = (s - 1 - y) & (s - 1);
      end
      return {y, x};
    end
    return {x, y};
  endfunction

  // distance to {x, y}, smallest quadrant first
  function automatic logic [63:0] index_to_grid(int unsigned lvls, logic [31:0] curve_idx);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    logic [31:0] s;
    logic [31:0] rx;
    logic [31:0] ry;
    int unsigned lvl;
    x = 0;
    y = 0;
    t = curve_idx;
    for (lvl = 0; lvl < lvls; lvl++) begin
      s  = 32'd1 << lvl;
      rx = (t >> 1) & 32'd1;
      ry = (t ^ rx) & 32'd1;
      {x, y} = fold_quadrant(s, rx, ry, x, y);
      x = x + s * rx;
      y = y + s * ry;
      t = t >> 2;
    end
    return {x, y};
  endfunction

  // {x, y} to distance, largest quadrant first
  function automatic logic [31:0] grid_to_index(int unsigned lvls, logic [31:0] x,
                                                logic [31:0] y);
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] rx;
    logic [31:0] ry;
    int unsigned lvl;
    d = 0;
    if (lvls == 0) begin
      return 0;
    end
    x = x & ((32'd1 << lvls) - 1);
    y = y & ((32'd1 << lvls) - 1);
    for (lvl = lvls; lvl > 0; lvl--) begin
      s  = 32'd1 << (lvl - 1);
      rx = ((x & s) != 0) ? 32'd1 : 32'd0;
      ry = ((y & s) != 0) ? 32'd1 : 32'd0;
      d  = d + s * s * ((3 * rx) ^ ry);
      x  = x & (s - 1);
      y  = y & (s - 1);
      {x, y} = fold_quadrant(s, rx, ry, x, y);
    end
    return d;
  endfunction

  function automatic curve_result_t predict_word(cmd_e cmd, logic [INDEX_W-1:0] curve_idx,
                                                 logic [COORD_W-1:0] col,
                                                 logic [COORD_W-1:0] row,
                                                 logic [ORDER_W-1:0] order);
    int unsigned   lvls;
    logic [63:0]   pos;
    curve_result_t r;
    lvls  = (order > MAX_ORDER) ? MAX_ORDER : order;
    r.kind = cmd;
    r.x    = '0;
    r.y    = '0;
    r.idx  = '0;
    if (cmd == CMD_IDX2XY) begin
      pos = index_to_grid(lvls, curve_idx);
      r.x = pos[32 +: COORD_W];
      r.y = pos[0 +: COORD_W];
    end else begin
      r.idx = grid_to_index(lvls, 32'(col), 32'(row));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    curve_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      order_q = ORDER_RESET;
      in_flight <= 0;
    end else begin
      // results first, a request accepted now cannot come out this edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing pending", rsp_i.index_out, '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.x_out !== want.x) begin
            report_mismatch("x_out", 32'(rsp_i.x_out), 32'(want.x));
          end
          if (rsp_i.y_out !== want.y) begin
            report_mismatch("y_out", 32'(rsp_i.y_out), 32'(want.y));
          end
          if (rsp_i.index_out !== want.idx) begin
            report_mismatch("index_out", rsp_i.index_out, want.idx);
          end
          if (want.kind == CMD_IDX2XY) coord_total++;
          else index_total++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(predict_word(cmd_e'(req_i.command), req_i.index_in,
                                          req_i.x_in, req_i.y_in, order_q));
      end
      if (psel && penable && pready && paddr == ORDER_ADDR) begin
        if (pwrite) begin
          order_q = pwdata[ORDER_W-1:0];
        end else if (prdata !== PDATA_W'(order_q)) begin
          report_mismatch("curve_order readback", prdata, PDATA_W'(order_q));
        end
      end
      in_flight <= expected_q.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives request words, result stalls and curve_order writes into the hilbert
// curve map; hcm_checker predicts and compares. depends on hcm_pkg, both channel
// interfaces, hilbert_curve_map and hcm_checker

module testbench;
  import hcm_pkg::*;

  localparam logic [PADDR_W-1:0] ORDER_ADDR = PADDR_W'(4 * REG_CURVE_ORDER);
  // hard cap far beyond the slowest correct run
  localparam int unsigned TIMEOUT_NS = 5_000_000;
  localparam int unsigned PARK_CYCLES = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  hcm_in_if  req_if ();
  hcm_out_if rsp_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned coord_cnt;
  int unsigned index_cnt;

  // knobs shared between the request side and the result side
  bit          tx_gaps_on  = 1'b1;
  bit          rx_gaps_on  = 1'b1;
  int unsigned park_len    = 0;
  int unsigned cur_eff     = int'(ORDER_RESET);
  int unsigned order_sets  = 1;
  int unsigned words_sent  = 0;

  hilbert_curve_map dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hcm_checker hcm_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .coord_cnt_o    (coord_cnt),
    .index_cnt_o    (index_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result words still pending", pending_cnt);
    $display("Mismatches found");
    $finish;
  end

  // result side: random back-pressure bursts, plus one long park on request
  initial begin : result_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (park_len != 0) begin
        // hold off long enough that the pipeline fills and input ready drops
        rsp_if.ready <= 1'b0;
        repeat (park_len) @(posedge clk_i);
        park_len = 0;
        rsp_if.ready <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // offer one request word, hold it until accepted, then maybe idle a burst
  task automatic send_word(input cmd_e cmd, input logic [INDEX_W-1:0] curve_idx,
                           input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.index_in <= curve_idx;
    req_if.x_in     <= col;
    req_if.y_in     <= row;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every pending result word to come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic apb_transfer(input bit wr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ORDER_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only called with the pipeline empty; junk in the unused upper bits, then read back
  task automatic set_order(input int unsigned order);
    drain();
    apb_transfer(1'b1, ($urandom() & ~PDATA_W'(32'h1F)) | PDATA_W'(order));
    apb_transfer(1'b0, '0);
    cur_eff = (order > MAX_ORDER) ? MAX_ORDER : order;
    order_sets++;
  endtask

  // random words biased toward the live part of the grid at the current order
  task automatic send_random(input int unsigned count);
    logic [INDEX_W-1:0] idx_mask;
    logic [COORD_W-1:0] xy_mask;
    logic [INDEX_W-1:0] curve_idx;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    int unsigned        pick;
    cmd_e               cmd;
    idx_mask = (cur_eff >= MAX_ORDER) ? '1 : INDEX_W'((64'd1 << (2 * cur_eff)) - 1);
    xy_mask  = (cur_eff >= MAX_ORDER) ? '1 : COORD_W'((32'd1 << cur_eff) - 1);
    repeat (count) begin
      cmd       = ($urandom_range(0, 1) != 0) ? CMD_XY2IDX : CMD_IDX2XY;
      pick      = $urandom_range(0, 9);
      curve_idx = $urandom();
      col       = COORD_W'($urandom());
      row       = COORD_W'($urandom());
      if (pick < 6) begin
        // in-range values
        curve_idx = curve_idx & idx_mask;
        col       = col & xy_mask;
        row       = row & xy_mask;
      end else if (pick == 6) begin
        // grid corners and the last curve position
        curve_idx = ($urandom_range(0, 1) != 0) ? idx_mask : '0;
        col       = ($urandom_range(0, 1) != 0) ? xy_mask : '0;
        row       = ($urandom_range(0, 1) != 0) ? xy_mask : '0;
      end else if (pick == 7) begin
        // only bits beyond the grid set, result must match an all-zero word
        curve_idx = curve_idx & ~idx_mask;
        col       = col & ~xy_mask;
        row       = row & ~xy_mask;
      end
      send_word(cmd, curve_idx, col, row);
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned words;
    int unsigned order;
    int unsigned guard;
    rst_ni         <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.command  <= CMD_IDX2XY;
    req_if.index_in <= '0;
    req_if.x_in     <= '0;
    req_if.y_in     <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset order of 13: first curve steps, last position,
    // index bits above 25 ignored, coordinate bits above 12 ignored, corners
    send_word(CMD_IDX2XY, 32'h0000_0000, '0, '0);
    send_word(CMD_IDX2XY, 32'h0000_0001, '0, '0);
    send_word(CMD_IDX2XY, 32'h0000_0002, '0, '0);
    send_word(CMD_IDX2XY, 32'h0000_0003, '0, '0);
    send_word(CMD_IDX2XY, 32'h03FF_FFFF, '0, '0);
    send_word(CMD_IDX2XY, 32'hFC00_0000, '0, '0);
    send_word(CMD_IDX2XY, 32'hFFFF_FFFF, '1, '1);
    send_word(CMD_XY2IDX, '0, 16'h0000, 16'h0000);
    send_word(CMD_XY2IDX, '0, 16'h1FFF, 16'h0000);
    send_word(CMD_XY2IDX, '0, 16'h0000, 16'h1FFF);
    send_word(CMD_XY2IDX, '0, 16'h1FFF, 16'h1FFF);
    send_word(CMD_XY2IDX, '0, 16'hE000, 16'hE000);
    send_word(CMD_XY2IDX, '1, 16'hFFFF, 16'hFFFF);
    // order zero: one-cell grid, everything maps to zero
    set_order(0);
    send_word(CMD_IDX2XY, 32'hFFFF_FFFF, '0, '0);
    send_word(CMD_XY2IDX, '0, 16'hFFFF, 16'hFFFF);
    send_word(CMD_IDX2XY, 32'h0000_0005, '0, '0);
    send_word(CMD_XY2IDX, '0, 16'h0001, 16'h0000);
    // order above the maximum saturates to 16
    set_order(31);
    send_word(CMD_IDX2XY, 32'hFFFF_FFFF, '0, '0);
    send_word(CMD_IDX2XY, 32'hAAAA_5555, '0, '0);
    send_word(CMD_XY2IDX, '0, 16'hFFFF, 16'h0000);
    send_word(CMD_XY2IDX, '0, 16'h8000, 16'hFFFF);
    // smallest non-trivial grid, two by two
    set_order(1);
    send_word(CMD_IDX2XY, 32'h0000_0002, '0, '0);
    send_word(CMD_IDX2XY, 32'hFFFF_FFFE, '0, '0);
    send_word(CMD_XY2IDX, '0, 16'h0001, 16'h0001);
    send_word(CMD_XY2IDX, '0, 16'hFFFE, 16'h0001);

    // random phases, one order setting each; each set_order drains first
    for (p = 0; p < 9; p++) begin
      case (p)
        0: begin order = 16; words = 300; end
        1: begin order = 1; words = 150; end
        2: begin order = $urandom_range(2, 15); words = 250; end
        3: begin order = 31; words = 200; end
        4: begin order = 17; words = 150; end
        5: begin order = $urandom_range(2, 15); words = 250; end
        6: begin order = 0; words = 60; end
        7: begin order = $urandom_range(1, 31); words = 250; end
        default: begin order = 16; words = 200; end
      endcase
      set_order(order);
      // one phase opens with a long result-side park while requests keep coming
      if (p == 2) park_len = PARK_CYCLES;
      // the closing phase runs back to back on both sides
      if (p == 8) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end
      send_random(words);
    end

    // all requests accepted; wait for the tail, then keep watching for strays
    req_if.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending_cnt != 0 && guard < 5000);
    repeat (16) @(posedge clk_i);

    $display("ran %0d request words: %0d index-to-xy and %0d xy-to-index results checked",
             words_sent, coord_cnt, index_cnt);
    $display("over %0d curve_order settings, incl. order 0, 1, 16, saturation and a long stall",
             order_sets);
    if (pending_cnt != 0) begin
      $display("%0d result words never arrived", pending_cnt);
    end
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
